### hw/rtl/fdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_pkg - framed data receiver shared definitions
// Result kinds, reply characters, register indexes, queue record type and
// the element size table.
// ----------------------------------------------------------------------------
package fdr_pkg;

  // Default counter width and queue depth
  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Fixed field widths
  localparam int unsigned MAX_BYTES_W = 24;
  localparam int unsigned INDEX_W     = 24;
  localparam int unsigned TOTAL_W     = 32;

  // Framing characters
  localparam logic [7:0]  START_MARK  = 8'h3C;   // '<'
  localparam logic [7:0]  FORMAT_BASE = 8'h30;   // '0'
  localparam logic [7:0]  FORMAT_LAST = 8'h36;   // '6'
  localparam logic [7:0]  REPLY_ACK   = 8'h61;   // 'a'
  localparam logic [7:0]  REPLY_FAIL  = 8'h43;   // 'C'
  localparam logic [7:0]  REPLY_OK    = 8'h5E;   // '^'
  localparam logic [7:0]  REPLY_NONE  = 8'h00;
  localparam logic [15:0] SUM_SEED    = 16'h1234;
  localparam logic [23:0] MAX_BYTES_RST = 24'hFF_FFFF;

  // Configuration register indexes
  localparam logic CFG_MAX_BYTES       = 1'b0;
  localparam logic CFG_EXPECTED_FORMAT = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_OK     = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  // One result record as it travels through the queue
  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data;
    logic [INDEX_W-1:0]   index;
    logic [7:0]           tag;
    logic [TOTAL_W-1:0]   count;
  } rec_t;

  // Element size as a left shift: sizes 1,1,2,2,4,4,4 for formats '0'..'6'
  function automatic logic [1:0] elem_shift(input logic [2:0] fmt_idx);
    logic [1:0] sh;
    unique case (fmt_idx)
      3'd0, 3'd1:       sh = 2'd0;
      3'd2, 3'd3:       sh = 2'd1;
      3'd4, 3'd5, 3'd6: sh = 2'd2;
      default:          sh = 2'd0;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/framed_data_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_data_receiver_top - framed data receiver
// Result path: the record is written into the queue at the byte transfer,
//   then loaded into the output register once that register is empty or
//   its transfer completes.
// Throughput: one byte per cycle; input stalls only while the record queue
//   is full.
// Reset (synchronous, rst_n low): parser hunts for '<', queue and output
//   register empty, max_bytes = 0xFFFFFF, expected_format = 0.
// ----------------------------------------------------------------------------
module framed_data_receiver_top #(
  parameter int unsigned COUNT_WIDTH = fdr_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = fdr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [fdr_pkg::MAX_BYTES_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           out_kind,
  output logic [7:0]                           out_reply_byte,
  output logic [7:0]                           out_data_byte,
  output logic [fdr_pkg::INDEX_W-1:0]          out_data_index,
  output logic [7:0]                           out_frame_tag,
  output logic [fdr_pkg::TOTAL_W-1:0]          out_element_count
);
  import fdr_pkg::*;

  logic q_full;
  logic push;
  rec_t push_rec;
  logic pop;
  logic head_valid;
  rec_t head_rec;

  // Parser
  fdr_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  // Record queue
  fdr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_rec  (head_rec)
  );

  // Output stage
  fdr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_rec         (head_rec),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_reply_byte   (out_reply_byte),
    .out_data_byte    (out_data_byte),
    .out_data_index   (out_data_index),
    .out_frame_tag    (out_frame_tag),
    .out_element_count(out_element_count)
  );

  // Parser never writes a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("record pushed into full queue");

  // Ack result carries the ack character
  a_ack_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ACK)) |-> (out_reply_byte == REPLY_ACK))
    else $error("ack result without ack reply");

  // Data results carry no reply and no element count
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DATA)) |->
      ((out_reply_byte == REPLY_NONE) && (out_element_count == '0)))
    else $error("data result with reply or count");

  // Output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

### hw/rtl/fdr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_front - frame parser
// Accepts received bytes, hunts for the start mark, collects the header,
// counts and sums payload bytes and checks the trailing checksum. Each byte
// that causes a result pushes one record into the queue.
// ----------------------------------------------------------------------------
module fdr_front #(
  parameter int unsigned COUNT_WIDTH = fdr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [fdr_pkg::MAX_BYTES_W-1:0] cfg_wdata,
  // byte input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_rx_byte,
  // queue side
  input  wire logic                            q_full,
  output logic                                 push,
  output fdr_pkg::rec_t                        push_rec
);
  import fdr_pkg::*;

  localparam int unsigned WANT_W = TOTAL_W + 2;
  localparam logic [WANT_W-1:0] LIMIT = (WANT_W'(1) << COUNT_WIDTH) - WANT_W'(1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_DATA,
    PH_SUM_LO,
    PH_SUM_HI
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]             fmt_r, fmt_nxt;
  logic [7:0]             tag_r, tag_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] target_r, target_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [15:0]            sum_r, sum_nxt;
  logic [7:0]             sum_lo_r, sum_lo_nxt;
  logic [MAX_BYTES_W-1:0] max_bytes_r;
  logic [7:0]             exp_fmt_r;

  logic                   accept;
  logic [1:0]             hdr_lane;
  logic [2:0]             fmt_idx;
  logic                   fmt_bad;
  logic [WANT_W-1:0]      want;
  logic [WANT_W-1:0]      cap;
  logic [WANT_W-1:0]      want_sat;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [31:0]            count_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Header helpers
  assign hdr_lane = 2'(hdr_cnt_r - 3'd2);
  assign fmt_idx  = 3'(fmt_r - FORMAT_BASE);
  assign fmt_bad  = (fmt_r < FORMAT_BASE) || (fmt_r > FORMAT_LAST) ||
                    ((exp_fmt_r != 8'd0) && (exp_fmt_r != fmt_r));

  // Payload target: size * count, saturated to max_bytes and counter range
  assign want     = WANT_W'(total_nxt) << elem_shift(fmt_idx);
  assign cap      = (WANT_W'(max_bytes_r) < LIMIT) ? WANT_W'(max_bytes_r) : LIMIT;
  assign want_sat = (want < cap) ? want : cap;

  assign count_inc = count_r + COUNT_WIDTH'(1);
  assign count_ext = 32'(count_r);

  // Parser next state and result record
  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    fmt_nxt     = fmt_r;
    tag_nxt     = tag_r;
    total_nxt   = total_r;
    target_nxt  = target_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    sum_lo_nxt  = sum_lo_r;
    push        = 1'b0;
    push_rec    = '{kind: KIND_ACK, data: 8'd0, index: '0, tag: tag_r, count: '0};

    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == START_MARK) begin
            phase_nxt   = PH_HEADER;
            hdr_cnt_nxt = 3'd0;
          end
        end

        PH_HEADER: begin
          if (hdr_cnt_r == 3'd0) begin
            fmt_nxt   = in_rx_byte;
            total_nxt = '0;
          end else if (hdr_cnt_r == 3'd1) begin
            tag_nxt = in_rx_byte;
          end else begin
            total_nxt[8*hdr_lane +: 8] = in_rx_byte;
          end
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          // last header byte: accept or reject the frame
          if (hdr_cnt_r == 3'd5) begin
            hdr_cnt_nxt   = 3'd0;
            push          = 1'b1;
            push_rec.tag  = tag_r;
            if (fmt_bad) begin
              phase_nxt     = PH_HUNT;
              push_rec.kind = KIND_REJECT;
            end else begin
              target_nxt    = COUNT_WIDTH'(want_sat);
              count_nxt     = '0;
              sum_nxt       = SUM_SEED;
              phase_nxt     = (want_sat == '0) ? PH_SUM_LO : PH_DATA;
              push_rec.kind = KIND_ACK;
            end
          end
        end

        PH_DATA: begin
          sum_nxt   = sum_r + 16'(in_rx_byte);
          count_nxt = count_inc;
          if ((count_inc == target_r) || (count_inc == '0)) begin
            phase_nxt = PH_SUM_LO;
          end
          push           = 1'b1;
          push_rec.kind  = KIND_DATA;
          push_rec.data  = in_rx_byte;
          push_rec.index = count_ext[INDEX_W-1:0];
        end

        PH_SUM_LO: begin
          sum_lo_nxt = in_rx_byte;
          phase_nxt  = PH_SUM_HI;
        end

        PH_SUM_HI: begin
          phase_nxt = PH_HUNT;
          push      = 1'b1;
          if ({in_rx_byte, sum_lo_r} == sum_r) begin
            push_rec.kind  = KIND_OK;
            push_rec.count = total_r;
          end else begin
            push_rec.kind  = KIND_FAIL;
          end
        end

        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hdr_cnt_r   <= 3'd0;
      fmt_r       <= 8'd0;
      tag_r       <= 8'd0;
      total_r     <= '0;
      target_r    <= '0;
      count_r     <= '0;
      sum_r       <= SUM_SEED;
      sum_lo_r    <= 8'd0;
      max_bytes_r <= MAX_BYTES_RST;
      exp_fmt_r   <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      fmt_r     <= fmt_nxt;
      tag_r     <= tag_nxt;
      total_r   <= total_nxt;
      target_r  <= target_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      sum_lo_r  <= sum_lo_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_BYTES:       max_bytes_r <= cfg_wdata;
          CFG_EXPECTED_FORMAT: exp_fmt_r   <= cfg_wdata[7:0];
          default:             ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fdr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_queue - result record queue
// Small register queue between parser and output stage; head is shown
// combinationally, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fdr_queue #(
  parameter int unsigned DEPTH = fdr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire fdr_pkg::rec_t push_rec,
  output logic         full,
  input  wire logic    pop,
  output logic         head_valid,
  output fdr_pkg::rec_t head_rec
);
  import fdr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fdr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdr_back - result output stage
// Takes records from the queue into the output register and forms the reply
// byte for each result kind.
// ----------------------------------------------------------------------------
module fdr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire fdr_pkg::rec_t               head_rec,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_kind,
  output logic [7:0]                       out_reply_byte,
  output logic [7:0]                       out_data_byte,
  output logic [fdr_pkg::INDEX_W-1:0]      out_data_index,
  output logic [7:0]                       out_frame_tag,
  output logic [fdr_pkg::TOTAL_W-1:0]      out_element_count
);
  import fdr_pkg::*;

  logic       valid_r;
  rec_t       rec_r;
  logic [7:0] reply_r;
  logic [7:0] reply_nxt;

  // Reply character per kind
  always_comb begin
    unique case (head_rec.kind)
      KIND_ACK:  reply_nxt = REPLY_ACK;
      KIND_OK:   reply_nxt = REPLY_OK;
      KIND_FAIL: reply_nxt = REPLY_FAIL;
      default:   reply_nxt = REPLY_NONE;
    endcase
  end

  // Load when the register is empty or its transfer completes
  assign pop = head_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r   <= head_rec;
      reply_r <= reply_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = rec_r.kind;
  assign out_reply_byte    = reply_r;
  assign out_data_byte     = rec_r.data;
  assign out_data_index    = rec_r.index;
  assign out_frame_tag     = rec_r.tag;
  assign out_element_count = rec_r.count;

endmodule
`default_nettype wire
